[rtl/ese_pkg.sv]
package ese_pkg;

    localparam int CHAR_W        = 16;
    localparam int CHAR_BITS_DEF = 16;
    localparam int HELD_DEPTH    = 7;
    localparam int HELD_IDX_W    = 3;
    localparam int NEED_W        = 4;

    localparam logic [7:0] C_BSL = 8'h5C;
    localparam logic [7:0] C_X   = 8'h78;
    localparam logic [7:0] C_U   = 8'h75;
    localparam logic [7:0] C_UU  = 8'h55;

    localparam logic [NEED_W-1:0] NEED_NARROW = 4'd2;
    localparam logic [NEED_W-1:0] NEED_U      = 4'd4;
    localparam logic [NEED_W-1:0] NEED_UU     = 4'd8;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } t_req;

    typedef struct packed {
        logic [CHAR_W-1:0] out_code;
        logic              string_end;
        logic              run_end;
    } t_rsp;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_BSL  = 3'b010,
        MODE_HEX  = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        LET_X  = 2'd0,
        LET_U  = 2'd1,
        LET_UU = 2'd2
    } t_letter;

    typedef enum logic [1:0] {
        SEL_FIRST = 2'd0,
        SEL_LET   = 2'd1,
        SEL_DIG   = 2'd2,
        SEL_TAIL  = 2'd3
    } t_sel;

    typedef struct packed {
        logic accept;
        logic emit;
        t_sel sel;
        logic is_final;
        logic rep_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic dec_pfx_bsl;
        logic dec_pfx_hex;
        logic dec_tail;
        logic tail_vld;
        logic n_zero;
        logic rep_last;
    } t_stat;

    // {hit, control code}
    function automatic logic [8:0] simple_code(input logic [CHAR_W-1:0] c);
        case (c)
            16'h0061: return {1'b1, 8'd7};
            16'h0062: return {1'b1, 8'd8};
            16'h0074: return {1'b1, 8'd9};
            16'h0066: return {1'b1, 8'd12};
            16'h006E: return {1'b1, 8'd10};
            16'h0072: return {1'b1, 8'd13};
            16'h0076: return {1'b1, 8'd11};
            16'h005C: return {1'b1, C_BSL};
            16'h0030: return {1'b1, 8'd0};
            default:  return 9'd0;
        endcase
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) begin
            return {1'b1, c[3:0]};
        end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                     (c >= 16'h0041 && c <= 16'h0046)) begin
            return {1'b1, c[3:0] + 4'd9};
        end else begin
            return 5'd0;
        end
    endfunction

    function automatic logic [7:0] letter_code(input t_letter l);
        case (l)
            LET_U:   return C_U;
            LET_UU:  return C_UU;
            default: return C_X;
        endcase
    endfunction

endpackage

[rtl/ese_ctrl.sv]
module ese_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ese_pkg::t_stat i_stat,
    output ese_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import ese_pkg::*;

    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_LET  = 4'b0010,
        S_DIG  = 4'b0100,
        S_TAIL = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   dec_pfx;

    assign dec_pfx = i_stat.dec_pfx_bsl | i_stat.dec_pfx_hex;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = SEL_FIRST;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_RUN: begin
                o_in_stall = ~i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.accept   = 1'b1;
                    o_cmd.emit     = dec_pfx | i_stat.dec_tail;
                    o_cmd.sel      = SEL_FIRST;
                    o_cmd.is_final = dec_pfx ? (i_stat.dec_pfx_bsl & ~i_stat.dec_tail) : 1'b1;
                    if (i_stat.dec_pfx_hex) begin
                        n_state = S_LET;
                    end else if (i_stat.dec_pfx_bsl && i_stat.dec_tail) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_LET: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_LET;
                    o_cmd.is_final = i_stat.n_zero & ~i_stat.tail_vld;
                    if (!i_stat.n_zero) begin
                        n_state = S_DIG;
                    end else if (i_stat.tail_vld) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_DIG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_DIG;
                    o_cmd.rep_step = 1'b1;
                    o_cmd.is_final = i_stat.rep_last & ~i_stat.tail_vld;
                    if (i_stat.rep_last) begin
                        n_state = i_stat.tail_vld ? S_TAIL : S_RUN;
                    end
                end
            end
            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_TAIL;
                    o_cmd.is_final = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/ese_dp.sv]
module ese_dp #(
    parameter int CHAR_BITS = ese_pkg::CHAR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  ese_pkg::t_req  i_req,
    input  logic           i_out_stall,
    input  ese_pkg::t_cmd  i_cmd,
    output ese_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output ese_pkg::t_rsp  o_out_rsp
);
    import ese_pkg::*;

    localparam int CODE_W = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

    logic                  r_wide;
    t_mode                 r_mode, n_mode;
    t_letter               r_letter, n_letter;
    logic [HELD_IDX_W-1:0] r_count, n_count;
    logic [NEED_W-1:0]     r_need, n_need;
    logic [CODE_W-1:0]     r_hex, n_hex;
    logic [7:0]            r_held [0:HELD_DEPTH-1];

    logic [HELD_IDX_W-1:0] r_n, n_n;
    logic                  r_tail_vld, n_tail_vld;
    logic [CODE_W-1:0]     r_tail, n_tail;
    logic                  r_last;
    logic [HELD_IDX_W-1:0] r_rep;

    logic                  r_ovalid;
    t_rsp                  r_orsp;

    logic [CHAR_W-1:0]     c;
    logic                  is_bsl;
    logic [8:0]            simp;
    logic [4:0]            dig;
    logic [CODE_W-1:0]     hv_next;
    logic                  complete;
    logic                  d_pfx_bsl, d_pfx_hex, d_hold;
    logic [CODE_W-1:0]     e_code;
    logic                  e_last;
    logic                  out_free;

    assign c        = i_req.char_code;
    assign is_bsl   = (c == CHAR_W'(C_BSL));
    assign simp     = simple_code(c);
    assign dig      = hex_digit(c);
    assign hv_next  = {r_hex[CODE_W-5:0], dig[3:0]};
    assign complete = (({1'b0, r_count} + 4'd1) >= r_need) || (r_count == 3'd7);
    assign out_free = ~r_ovalid | ~i_out_stall;

    always_comb begin
        n_mode     = r_mode;
        n_letter   = r_letter;
        n_count    = r_count;
        n_need     = r_need;
        n_hex      = r_hex;
        n_n        = '0;
        n_tail_vld = 1'b0;
        n_tail     = c[CODE_W-1:0];
        d_pfx_bsl  = 1'b0;
        d_pfx_hex  = 1'b0;
        d_hold     = 1'b0;
        unique case (r_mode)
            MODE_IDLE: begin
                if (is_bsl) begin
                    if (i_req.is_last) begin
                        n_tail_vld = 1'b1;
                    end else begin
                        n_mode = MODE_BSL;
                    end
                end else begin
                    n_tail_vld = 1'b1;
                end
            end
            MODE_BSL: begin
                n_mode = MODE_IDLE;
                if (simp[8]) begin
                    n_tail_vld = 1'b1;
                    n_tail     = CODE_W'(simp[7:0]);
                end else if (c == CHAR_W'(C_X) || c == CHAR_W'(C_U) ||
                             c == CHAR_W'(C_UU)) begin
                    n_count = '0;
                    n_hex   = '0;
                    if (c == CHAR_W'(C_X)) begin
                        n_letter = LET_X;
                        n_need   = NEED_NARROW;
                    end else if (c == CHAR_W'(C_U)) begin
                        n_letter = LET_U;
                        n_need   = r_wide ? NEED_U : NEED_NARROW;
                    end else begin
                        n_letter = LET_UU;
                        n_need   = r_wide ? NEED_UU : NEED_NARROW;
                    end
                    if (i_req.is_last) begin
                        d_pfx_hex = 1'b1;
                    end else begin
                        n_mode = MODE_HEX;
                    end
                end else begin
                    d_pfx_bsl  = 1'b1;
                    n_tail_vld = 1'b1;
                end
            end
            MODE_HEX: begin
                if (dig[4]) begin
                    n_hex = hv_next;
                    if (complete) begin
                        n_tail_vld = 1'b1;
                        n_tail     = hv_next;
                        n_mode     = MODE_IDLE;
                        n_count    = '0;
                    end else begin
                        d_hold  = 1'b1;
                        n_count = r_count + 3'd1;
                        if (i_req.is_last) begin
                            d_pfx_hex = 1'b1;
                            n_n       = r_count + 3'd1;
                            n_mode    = MODE_IDLE;
                        end
                    end
                end else begin
                    d_pfx_hex = 1'b1;
                    n_n       = r_count;
                    n_mode    = MODE_IDLE;
                    if (is_bsl) begin
                        if (i_req.is_last) begin
                            n_tail_vld = 1'b1;
                        end else begin
                            n_mode = MODE_BSL;
                        end
                    end else begin
                        n_tail_vld = 1'b1;
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_comb begin
        e_code = r_tail;
        e_last = r_last;
        unique case (i_cmd.sel)
            SEL_FIRST: begin
                e_code = (d_pfx_bsl | d_pfx_hex) ? CODE_W'(C_BSL) : n_tail;
                e_last = i_req.is_last;
            end
            SEL_LET:  e_code = CODE_W'(letter_code(r_letter));
            SEL_DIG:  e_code = CODE_W'(r_held[r_rep]);
            SEL_TAIL: e_code = r_tail;
            default:  e_code = r_tail;
        endcase
    end

    always_comb begin
        o_stat.out_free    = out_free;
        o_stat.dec_pfx_bsl = d_pfx_bsl;
        o_stat.dec_pfx_hex = d_pfx_hex;
        o_stat.dec_tail    = n_tail_vld;
        o_stat.tail_vld    = r_tail_vld;
        o_stat.n_zero      = (r_n == '0);
        o_stat.rep_last    = (({1'b0, r_rep} + 4'd1) == {1'b0, r_n});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide     <= 1'b1;
            r_mode     <= MODE_IDLE;
            r_letter   <= LET_X;
            r_count    <= '0;
            r_need     <= '0;
            r_hex      <= '0;
            r_ovalid   <= 1'b0;
            r_tail_vld <= 1'b0;
            r_n        <= '0;
            r_rep      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wide <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_mode     <= n_mode;
                r_letter   <= n_letter;
                r_count    <= n_count;
                r_need     <= n_need;
                r_hex      <= n_hex;
                r_n        <= n_n;
                r_tail_vld <= n_tail_vld;
                r_rep      <= '0;
            end else if (i_cmd.rep_step) begin
                r_rep <= r_rep + 3'd1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tail <= n_tail;
            r_last <= i_req.is_last;
            if (d_hold) begin
                r_held[r_count] <= c[7:0];
            end
        end
        if (i_cmd.emit) begin
            r_orsp.out_code   <= CHAR_W'(e_code);
            r_orsp.string_end <= i_cmd.is_final & e_last;
            r_orsp.run_end    <= i_cmd.is_final;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_rsp   = r_orsp;

endmodule

[rtl/escape_sequence_expander_unit.sv]
// channel   direction  handshake                       payload
// config    in         i_cfg_we                        i_cfg_wdata (wide escapes)
// request   in         i_in_valid / o_in_stall         i_in_req  (char_code, is_last)
// result    out        o_out_valid / i_out_stall       o_out_rsp (out_code, string_end, run_end)
//
// A request yielding zero or one result raises no o_in_stall of its own; back-to-back requests run
// at full rate while the output register is free. A request yielding k > 1 results (failed escape replay)
// holds o_in_stall till its last result; the single output register sends one result per cycle unless stalled.
// Synchronous active-low reset: parser idle, wide escapes on, output register empty.
// i_out_stall holds the output register; a new request is taken while it drains.
module escape_sequence_expander_unit #(
    parameter int CHAR_BITS = ese_pkg::CHAR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_in_valid,
    input  ese_pkg::t_req i_in_req,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output ese_pkg::t_rsp o_out_rsp,
    input  logic          i_out_stall
);
    import ese_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ese_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ese_dp #(
        .CHAR_BITS (CHAR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_req),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

[tb/sv/tb_escape_sequence_expander_unit.sv]
`timescale 1ns / 100ps

import ese_pkg::*;

class escape_scoreboard;
    bit            wide;
    t_mode         mode;
    t_letter       letter;
    logic [3:0]    n_dig;
    logic [3:0]    n_need;
    logic [15:0]   acc;
    logic [7:0]    held [7];
    logic [15:0]   step_out [$];
    t_rsp          pending_chars [$];
    int            fails;

    function new();
        wide   = 1'b1;
        mode   = MODE_IDLE;
        letter = LET_X;
        n_dig  = '0;
        n_need = '0;
        acc    = '0;
        foreach (held[i]) begin
            held[i] = '0;
        end
        fails  = 0;
    endfunction

    function logic [15:0] letter_char(t_letter l);
        case (l)
            LET_U:   return 16'(C_U);
            LET_UU:  return 16'(C_UU);
            default: return 16'(C_X);
        endcase
    endfunction

    function int nibble_of(logic [15:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) return int'(c - 16'h0030);
        if (c >= 16'h0061 && c <= 16'h0066) return int'(c - 16'h0061) + 10;
        if (c >= 16'h0041 && c <= 16'h0046) return int'(c - 16'h0041) + 10;
        return -1;
    endfunction

    function bit control_of(input logic [15:0] c, output logic [15:0] v);
        bit hit;
        hit = 1'b1;
        case (c)
            16'h0061: v = 16'd7;
            16'h0062: v = 16'd8;
            16'h0074: v = 16'd9;
            16'h0066: v = 16'd12;
            16'h006E: v = 16'd10;
            16'h0072: v = 16'd13;
            16'h0076: v = 16'd11;
            16'h005C: v = 16'(C_BSL);
            16'h0030: v = 16'd0;
            default: begin
                v   = '0;
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    function void put(logic [15:0] c);
        step_out = {step_out, c};
    endfunction

    function void take_plain(logic [15:0] c);
        if (c == 16'(C_BSL)) begin
            mode = MODE_BSL;
        end else begin
            put(c);
        end
    endfunction

    function void open_hex(t_letter l, logic [3:0] need);
        letter = l;
        n_need = need;
        n_dig  = '0;
        acc    = '0;
        mode   = MODE_HEX;
    endfunction

    // replay whatever escape prefix is still held
    function void flush_held();
        if (mode == MODE_BSL) begin
            put(16'(C_BSL));
        end else if (mode == MODE_HEX) begin
            put(16'(C_BSL));
            put(letter_char(letter));
            for (int i = 0; i < n_dig && i < 7; i++) begin
                put({8'h00, held[i]});
            end
        end
        mode = MODE_IDLE;
    endfunction

    function void decode_char(t_req r);
        logic [15:0] c;
        logic [15:0] ctl;
        int          d;
        t_rsp        e;
        c = r.char_code;
        step_out.delete();
        case (mode)
            MODE_BSL: begin
                mode = MODE_IDLE;
                if (control_of(c, ctl)) begin
                    put(ctl);
                end else if (c == 16'(C_X)) begin
                    open_hex(LET_X, NEED_NARROW);
                end else if (c == 16'(C_U)) begin
                    open_hex(LET_U, wide ? NEED_U : NEED_NARROW);
                end else if (c == 16'(C_UU)) begin
                    open_hex(LET_UU, wide ? NEED_UU : NEED_NARROW);
                end else begin
                    put(16'(C_BSL));
                    take_plain(c);
                end
            end
            MODE_HEX: begin
                d = nibble_of(c);
                if (d < 0) begin
                    flush_held();
                    take_plain(c);
                end else begin
                    acc = (acc << 4) + 16'(d);
                    if (n_dig + 1 >= n_need || n_dig >= 7) begin
                        put(acc);
                        mode  = MODE_IDLE;
                        n_dig = '0;
                    end else begin
                        held[n_dig[2:0]] = c[7:0];
                        n_dig++;
                    end
                end
            end
            default: take_plain(c);
        endcase
        if (r.is_last) begin
            flush_held();
        end
        foreach (step_out[k]) begin
            e.out_code   = step_out[k];
            e.run_end    = (k == step_out.size() - 1);
            e.string_end = e.run_end && r.is_last;
            pending_chars = {pending_chars, e};
        end
    endfunction

    task report(string msg);
        fails++;
        if (fails <= 100) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task check_char(t_rsp got);
        t_rsp want;
        if (pending_chars.size() == 0) begin
            report($sformatf("unexpected result out_code=%h", got.out_code));
            return;
        end
        want = pending_chars.pop_front();
        if (got.out_code !== want.out_code) begin
            report($sformatf("out_code got %h want %h", got.out_code, want.out_code));
        end
        if (got.string_end !== want.string_end) begin
            report($sformatf("string_end got %b want %b (code %h)",
                             got.string_end, want.string_end, want.out_code));
        end
        if (got.run_end !== want.run_end) begin
            report($sformatf("run_end got %b want %b (code %h)",
                             got.run_end, want.run_end, want.out_code));
        end
    endtask
endclass

module tb_escape_sequence_expander_unit;

    localparam int RX_HOLD   = 80;
    localparam int IDLE_PCT  = 7;
    localparam int QUIET_MAX = 3000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic in_valid;
    t_req in_req;
    logic in_stall;
    logic out_valid;
    t_rsp out_rsp;
    logic out_stall;

    escape_scoreboard sb;
    bit               idle_on;
    bit               cfg_wide;
    int               items_sent;
    int               hold_reqs;
    int               quiet;

    escape_sequence_expander_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_rsp   (out_rsp),
        .i_out_stall (out_stall)
    );

    always #5 clk = ~clk;

    // receiver: random stalls plus long hold-offs on request
    initial begin
        int seen;
        int left;
        seen      = 0;
        left      = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                left = RX_HOLD;
            end
            if (left > 0) begin
                left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_char(out_rsp);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_MAX) begin
            $display("timeout: no progress");
            $display("CHECK FAILED");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays up on return
    task automatic send_char(input logic [15:0] c, input logic last);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{char_code: c, is_last: last};
        do begin
            @(posedge clk);
        end while (in_stall);
        sb.decode_char(in_req);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_chars.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.wide   = v;
        cfg_wide  = v;
    endtask

    function automatic logic [15:0] rand_digit();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 16'h0030 + 16'(v);
        if (v < 16) return 16'h0061 + 16'(v - 10);
        return 16'h0041 + 16'(v - 16);
    endfunction

    // non-hex characters, mostly at the edges of the digit ranges
    function automatic logic [15:0] bad_digit();
        case ($urandom_range(0, 9))
            0: return 16'h002F;
            1: return 16'h003A;
            2: return 16'h0040;
            3: return 16'h0047;
            4: return 16'h0060;
            5: return 16'h0067;
            6: return 16'(C_BSL);
            7: return 16'h0130;
            8: return 16'h0000;
            default: return 16'($urandom) | 16'h0100;
        endcase
    endfunction

    function automatic logic [15:0] unknown_letter();
        case ($urandom_range(0, 5))
            0: return 16'h0071;
            1: return 16'h0058;
            2: return 16'h0031;
            3: return 16'h003F;
            4: return 16'h0161;
            default: return 16'($urandom) | 16'h8000;
        endcase
    endfunction

    function automatic logic [15:0] simple_letter();
        case ($urandom_range(0, 8))
            0: return 16'h0061;
            1: return 16'h0062;
            2: return 16'h0074;
            3: return 16'h0066;
            4: return 16'h006E;
            5: return 16'h0072;
            6: return 16'h0076;
            7: return 16'(C_BSL);
            default: return 16'h0030;
        endcase
    endfunction

    function automatic logic [15:0] plain_char();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return {8'h00, 8'($urandom)};
            default: return 16'($urandom_range(16'h0020, 16'h007E));
        endcase
    endfunction

    function automatic int digits_for(t_letter l);
        if (l == LET_X || !cfg_wide) return int'(NEED_NARROW);
        return (l == LET_U) ? int'(NEED_U) : int'(NEED_UU);
    endfunction

    task automatic send_random_string();
        logic [15:0] chars [$];
        int          kind;
        int          need;
        int          n;
        t_letter     ltr;
        repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                chars = {chars, plain_char()};
            end else if (kind < 50) begin
                chars = {chars, 16'(C_BSL)};
                chars = {chars, simple_letter()};
            end else if (kind < 92) begin
                ltr  = t_letter'($urandom_range(0, 2));
                need = digits_for(ltr);
                n    = (kind < 80) ? need : $urandom_range(0, need - 1);
                chars = {chars, 16'(C_BSL)};
                chars = {chars, sb.letter_char(ltr)};
                repeat (n) chars = {chars, rand_digit()};
                if (kind >= 80) begin
                    chars = {chars, bad_digit()};
                end
            end else begin
                chars = {chars, 16'(C_BSL)};
                chars = {chars, unknown_letter()};
            end
        end
        // string cut off inside an escape
        if ($urandom_range(0, 7) == 0) begin
            chars = {chars, 16'(C_BSL)};
            if ($urandom_range(0, 1)) begin
                ltr = t_letter'($urandom_range(0, 2));
                chars = {chars, sb.letter_char(ltr)};
                repeat ($urandom_range(0, digits_for(ltr) - 1)) chars = {chars, rand_digit()};
            end
        end
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic directed_part();
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_char(16'(C_BSL), 1'b0);        // \n
        send_char(16'h006E, 1'b0);
        send_char(16'(C_BSL), 1'b0);        // \0
        send_char(16'h0030, 1'b0);
        send_char(16'(C_BSL), 1'b0);        // unknown letter
        send_char(16'h0071, 1'b0);
        send_char(16'(C_BSL), 1'b0);        // \uFf09
        send_char(16'(C_U), 1'b0);
        send_char(16'h0046, 1'b0);
        send_char(16'h0066, 1'b0);
        send_char(16'h0030, 1'b0);
        send_char(16'h0039, 1'b0);
        send_char(16'(C_BSL), 1'b0);        // \U12g: bad digit
        send_char(16'(C_UU), 1'b0);
        send_char(16'h0031, 1'b0);
        send_char(16'h0032, 1'b0);
        send_char(16'h0067, 1'b0);
        send_char(16'(C_BSL), 1'b0);        // \xA then \a: backslash restarts
        send_char(16'(C_X), 1'b0);
        send_char(16'h0041, 1'b0);
        send_char(16'(C_BSL), 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(16'(C_BSL), 1'b1);        // string ends inside an escape
    endtask

    initial begin
        sb         = new();
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        in_valid   = 1'b0;
        in_req     = '0;
        idle_on    = 1'b1;
        cfg_wide   = 1'b1;
        items_sent = 0;
        hold_reqs  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_cfg(1'b1);
        directed_part();
        drain();

        write_cfg(1'b0);
        while (items_sent < 50) send_random_string();
        drain();

        write_cfg(1'b1);
        idle_on <= 1'b0;
        while (items_sent < 70) send_random_string();
        hold_reqs <= hold_reqs + 1;
        while (items_sent < 90) send_random_string();
        idle_on <= 1'b1;
        drain();

        write_cfg(1'b0);
        while (items_sent < 110) send_random_string();
        drain();

        repeat (10) @(negedge clk);
        if (sb.fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ese_pkg.sv
rtl/ese_ctrl.sv
rtl/ese_dp.sv
rtl/escape_sequence_expander_unit.sv
tb/sv/tb_escape_sequence_expander_unit.sv
